// File: rtl/core/sad_pkg.sv
// sidechain ducker package: shared constants and rounding helper
// used by sad_log2, sad_div and sidechain_audio_ducker
package sad_pkg;

    localparam int unsigned ACC_W   = 42;
    localparam int unsigned LOG_W   = 22;
    localparam int unsigned GAIN_W  = 17;
    localparam int unsigned DIVS_W  = 22;

    localparam logic [GAIN_W-1:0] UNITY    = 17'd65536;
    localparam logic [GAIN_W-1:0] GAIN_MAX = 17'd131071;
    localparam logic [ACC_W-1:0]  SUM_MAX  = {ACC_W{1'b1}};

    localparam logic signed [32:0] DB_PER_LOG2_Q16 = 33'sd197283;
    localparam logic signed [32:0] LOG2_PER_DB_Q24 = 33'sd2786635;
    localparam logic signed [16:0] FLOOR_DB_Q88    = -17'sd24576;
    localparam logic signed [23:0] LOG2_OFS_30     = 24'sd1966080;
    localparam logic signed [23:0] LOG2_OFS_16     = 24'sd1048576;

    // register indexes of the configuration port
    localparam logic [2:0] REG_ENABLED   = 3'd0;
    localparam logic [2:0] REG_DETECT    = 3'd1;
    localparam logic [2:0] REG_THRESHOLD = 3'd2;
    localparam logic [2:0] REG_DUCK_LVL  = 3'd3;
    localparam logic [2:0] REG_RATIO     = 3'd4;
    localparam logic [2:0] REG_ATTACK    = 3'd5;
    localparam logic [2:0] REG_RELEASE   = 3'd6;
    localparam logic [2:0] REG_MASK      = 3'd7;

    // arithmetic right shift rounding half away from zero
    function automatic logic signed [65:0] shr_round(input logic signed [65:0] v,
                                                     input int unsigned sh);
        logic [65:0] half;
        logic [65:0] mag;
        logic [65:0] q;
        half = 66'd1 << (sh - 1);
        mag  = v[65] ? (66'd0 - 66'(v)) : 66'(v);
        q    = (mag + half) >> sh;
        return v[65] ? $signed(66'd0 - q) : $signed(q);
    endfunction

endpackage

// File: rtl/core/sidechain_audio_ducker.sv
// sidechain ducker top: block level detect, dB gain decision, envelope smoothing
// non-last samples are accumulated while idle; the last sample starts the block computation,
// which runs through the shared log2 unit (up to 19 calls) and the step divider;
// input stalls until the block result is taken into the output register
// reset (rst_n low, async): registers to defaults, envelope and accumulators zero
// depends on sad_pkg, sad_log2, sad_div
module sidechain_audio_ducker #(
    parameter int BLOCK_MAX = 4096,
    parameter int TRACKS    = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    // tdata: track_id[5:0], sample[21:6], zero pad[23:22]
    input  logic [23:0] s_tdata,
    input  logic        s_tlast,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: output_gain[16:0], target_gain[33:17], is_ducking[34],
    //        duck_amount_db[51:35], started[52], ended[53], zero pad[55:54]
    output logic [55:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    localparam int CNT_W = $clog2(BLOCK_MAX + 1);

    typedef enum logic [4:0] {
        S_IDLE, S_START, S_LOGA, S_LOGA_W, S_LOGB, S_LOGB_W, S_LEVEL_MUL, S_LEVEL,
        S_CMP, S_DUCK_MUL, S_DUCK, S_EXP_CHK, S_EXP_MUL, S_EXP, S_GAIN, S_GAIN_W,
        S_STEP, S_STEP_W, S_ENV, S_OUT
    } state_t;

    // configuration registers
    logic               enabled_reg;
    logic               detect_peak_reg;
    logic signed [15:0] threshold_reg;
    logic signed [15:0] duck_level_reg;
    logic [16:0]        ratio_reg;
    logic [15:0]        attack_reg;
    logic [15:0]        release_reg;
    logic [63:0]        mask_reg;

    // block state and sequencer
    state_t             state_reg;
    logic [41:0]        sum_reg;
    logic [14:0]        peak_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [5:0]         track_reg;
    logic [16:0]        env_reg;
    logic               flag_reg;
    logic [21:0]        loga_reg;
    logic signed [23:0] l2_reg;
    logic signed [17:0] level_reg;
    logic signed [16:0] duck_reg;
    logic signed [23:0] e_reg;
    logic [16:0]        gain_reg;
    logic [4:0]         bit_reg;
    logic [16:0]        target_reg;
    logic               duck_now_reg;
    logic               down_reg;
    logic [16:0]        step_reg;
    logic signed [65:0] prod_reg;
    logic [16:0]        res_gain_reg;
    logic               started_reg;
    logic               ended_reg;
    logic [55:0]        m_tdata_reg;
    logic               m_tvalid_reg;

    logic               cfg_fire;
    logic               in_fire;
    logic [5:0]         in_track;
    logic signed [15:0] in_sample;
    logic [16:0]        mag;
    logic [30:0]        sq;
    logic [42:0]        sum_add;
    logic [14:0]        mag_sat;
    logic               has_level;
    logic               is_target;
    logic [16:0]        cand;
    logic               log_start;
    logic [41:0]        log_value;
    logic               log_done;
    logic [21:0]        log_res;
    logic               div_start;
    logic [15:0]        ms_sel;
    logic               down_sel;
    logic               div_done;
    logic [16:0]        div_q;
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [19:0] diff;
    logic signed [65:0] level_rnd;
    logic signed [65:0] duck_rnd;
    logic signed [65:0] e_rnd;
    logic signed [16:0] duck_sat;
    logic signed [23:0] cand_log;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign s_tready  = (state_reg == S_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign in_track  = s_tdata[5:0];
    assign in_sample = $signed(s_tdata[21:6]);
    assign m_tdata   = m_tdata_reg;
    assign m_tvalid  = m_tvalid_reg;

    // per-sample accumulation terms
    assign mag     = in_sample[15] ? (17'd0 - {in_sample[15], in_sample})
                                   : {1'b0, in_sample};
    assign sq      = 31'(mag * mag);
    assign sum_add = {1'b0, sum_reg} + 43'(sq);
    assign mag_sat = (mag > 17'd32767) ? 15'd32767 : mag[14:0];

    assign has_level = detect_peak_reg ? (peak_reg != '0) : (sum_reg != '0);
    assign is_target = (32'(track_reg) < 32'(TRACKS)) && mask_reg[track_reg];
    assign cand      = gain_reg | (17'd1 << bit_reg);
    assign cand_log  = $signed({2'b00, log_res}) - sad_pkg::LOG2_OFS_16;

    // envelope direction and divider request
    assign down_sel  = target_reg < env_reg;
    assign ms_sel    = down_sel ? attack_reg : release_reg;
    assign div_start = (state_reg == S_STEP) && (ms_sel != '0);

    // shared log2 unit requests
    always_comb
    begin
        log_start = 1'b0;
        log_value = '0;
        case (state_reg)
            S_LOGA:
            begin
                log_start = 1'b1;
                log_value = detect_peak_reg ? prod_reg[41:0] : sum_reg;
            end
            S_LOGB:
            begin
                log_start = 1'b1;
                log_value = 42'(cnt_reg);
            end
            S_GAIN:
            begin
                log_start = 1'b1;
                log_value = 42'(cand);
            end
            default:
            begin
                log_start = 1'b0;
            end
        endcase
    end

    // shared multiplier operand select
    assign diff = 20'(duck_level_reg) - (20'(level_reg) - 20'(threshold_reg));
    always_comb
    begin
        case (state_reg)
            S_START:
            begin
                mul_a = 33'(peak_reg);
                mul_b = 33'(peak_reg);
            end
            S_LEVEL_MUL:
            begin
                mul_a = 33'(l2_reg - sad_pkg::LOG2_OFS_30);
                mul_b = sad_pkg::DB_PER_LOG2_Q16;
            end
            S_DUCK_MUL:
            begin
                mul_a = 33'(diff);
                mul_b = $signed({16'd0, ratio_reg});
            end
            S_EXP_MUL:
            begin
                mul_a = 33'(duck_reg);
                mul_b = sad_pkg::LOG2_PER_DB_Q24;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // rounding and clamping of the product
    assign level_rnd = sad_pkg::shr_round(prod_reg, 24);
    assign duck_rnd  = sad_pkg::shr_round(prod_reg, 16);
    assign e_rnd     = duck_rnd;
    always_comb
    begin
        if (duck_rnd < -66'sd65536)
            duck_sat = -17'sd65536;
        else if (duck_rnd > 66'sd65535)
            duck_sat = 17'sd65535;
        else
            duck_sat = duck_rnd[16:0];
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg     <= 1'b1;
            detect_peak_reg <= 1'b0;
            threshold_reg   <= -16'sd10240;
            duck_level_reg  <= -16'sd5120;
            ratio_reg       <= 17'd16384;
            attack_reg      <= 16'd10;
            release_reg     <= 16'd300;
            mask_reg        <= '0;
        end
        else if (cfg_fire)
        begin
            unique case (cfg_index)
                sad_pkg::REG_ENABLED:   enabled_reg     <= cfg_data[0];
                sad_pkg::REG_DETECT:    detect_peak_reg <= cfg_data[0];
                sad_pkg::REG_THRESHOLD: threshold_reg   <= $signed(cfg_data[15:0]);
                sad_pkg::REG_DUCK_LVL:  duck_level_reg  <= $signed(cfg_data[15:0]);
                sad_pkg::REG_RATIO:     ratio_reg       <= cfg_data[16:0];
                sad_pkg::REG_ATTACK:    attack_reg      <= cfg_data[15:0];
                sad_pkg::REG_RELEASE:   release_reg     <= cfg_data[15:0];
                sad_pkg::REG_MASK:      mask_reg        <= cfg_data;
                default:                mask_reg        <= mask_reg;
            endcase
        end
    end

    // block sequencer, accumulators, envelope and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            sum_reg      <= '0;
            peak_reg     <= '0;
            cnt_reg      <= '0;
            track_reg    <= '0;
            env_reg      <= '0;
            flag_reg     <= 1'b0;
            loga_reg     <= '0;
            l2_reg       <= '0;
            level_reg    <= '0;
            duck_reg     <= '0;
            e_reg        <= '0;
            gain_reg     <= '0;
            bit_reg      <= '0;
            target_reg   <= '0;
            duck_now_reg <= 1'b0;
            down_reg     <= 1'b0;
            step_reg     <= '0;
            prod_reg     <= '0;
            res_gain_reg <= '0;
            started_reg  <= 1'b0;
            ended_reg    <= 1'b0;
            m_tdata_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            prod_reg <= mul_a * mul_b;
            if (m_tvalid_reg && m_tready)
                m_tvalid_reg <= 1'b0;
            if (cfg_fire && (cfg_index == sad_pkg::REG_ENABLED) && !cfg_data[0])
            begin
                env_reg  <= '0;
                flag_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        if (cnt_reg < CNT_W'(BLOCK_MAX))
                        begin
                            sum_reg  <= sum_add[42] ? sad_pkg::SUM_MAX : sum_add[41:0];
                            peak_reg <= (mag_sat > peak_reg) ? mag_sat : peak_reg;
                            cnt_reg  <= cnt_reg + 1'b1;
                        end
                        if (s_tlast)
                        begin
                            track_reg <= in_track;
                            state_reg <= S_START;
                        end
                    end
                end
                S_START:
                begin
                    duck_now_reg <= 1'b0;
                    duck_reg     <= '0;
                    target_reg   <= sad_pkg::UNITY;
                    if (!enabled_reg)
                    begin
                        env_reg      <= '0;
                        flag_reg     <= 1'b0;
                        res_gain_reg <= sad_pkg::UNITY;
                        started_reg  <= 1'b0;
                        ended_reg    <= 1'b0;
                        state_reg    <= S_OUT;
                    end
                    else if (!has_level)
                        state_reg <= S_STEP;
                    else
                        state_reg <= S_LOGA;
                end
                S_LOGA: state_reg <= S_LOGA_W;
                S_LOGA_W:
                begin
                    if (log_done)
                    begin
                        loga_reg <= log_res;
                        if (detect_peak_reg)
                        begin
                            l2_reg    <= $signed({2'b00, log_res});
                            state_reg <= S_LEVEL_MUL;
                        end
                        else
                            state_reg <= S_LOGB;
                    end
                end
                S_LOGB: state_reg <= S_LOGB_W;
                S_LOGB_W:
                begin
                    if (log_done)
                    begin
                        l2_reg    <= $signed({2'b00, loga_reg}) - $signed({2'b00, log_res});
                        state_reg <= S_LEVEL_MUL;
                    end
                end
                S_LEVEL_MUL: state_reg <= S_LEVEL;
                S_LEVEL:
                begin
                    level_reg <= level_rnd[17:0];
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    if ((level_reg > 18'(threshold_reg)) && is_target)
                        state_reg <= S_DUCK_MUL;
                    else
                        state_reg <= S_STEP;
                end
                S_DUCK_MUL: state_reg <= S_DUCK;
                S_DUCK:
                begin
                    duck_reg     <= duck_sat;
                    duck_now_reg <= 1'b1;
                    state_reg    <= S_EXP_CHK;
                end
                S_EXP_CHK:
                begin
                    if (duck_reg <= sad_pkg::FLOOR_DB_Q88)
                    begin
                        target_reg <= '0;
                        state_reg  <= S_STEP;
                    end
                    else
                        state_reg <= S_EXP_MUL;
                end
                S_EXP_MUL: state_reg <= S_EXP;
                S_EXP:
                begin
                    e_reg     <= e_rnd[23:0];
                    gain_reg  <= '0;
                    bit_reg   <= 5'd16;
                    state_reg <= S_GAIN;
                end
                S_GAIN: state_reg <= S_GAIN_W;
                S_GAIN_W:
                begin
                    if (log_done)
                    begin
                        if (cand_log <= e_reg)
                            gain_reg <= cand;
                        if (bit_reg == 5'd0)
                        begin
                            target_reg <= (cand_log <= e_reg) ? cand : gain_reg;
                            state_reg  <= S_STEP;
                        end
                        else
                        begin
                            bit_reg   <= bit_reg - 5'd1;
                            state_reg <= S_GAIN;
                        end
                    end
                end
                S_STEP:
                begin
                    down_reg <= down_sel;
                    if (ms_sel == '0)
                    begin
                        step_reg  <= sad_pkg::GAIN_MAX;
                        state_reg <= S_ENV;
                    end
                    else
                        state_reg <= S_STEP_W;
                end
                S_STEP_W:
                begin
                    if (div_done)
                    begin
                        step_reg  <= div_q;
                        state_reg <= S_ENV;
                    end
                end
                S_ENV:
                begin
                    if (down_reg)
                    begin
                        if ((env_reg - target_reg) <= step_reg)
                        begin
                            env_reg      <= target_reg;
                            res_gain_reg <= target_reg;
                        end
                        else
                        begin
                            env_reg      <= env_reg - step_reg;
                            res_gain_reg <= env_reg - step_reg;
                        end
                    end
                    else
                    begin
                        if ((target_reg - env_reg) <= step_reg)
                        begin
                            env_reg      <= target_reg;
                            res_gain_reg <= target_reg;
                        end
                        else
                        begin
                            env_reg      <= env_reg + step_reg;
                            res_gain_reg <= env_reg + step_reg;
                        end
                    end
                    started_reg <= duck_now_reg && !flag_reg;
                    ended_reg   <= !duck_now_reg && flag_reg;
                    flag_reg    <= duck_now_reg;
                    state_reg   <= S_OUT;
                end
                S_OUT:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tdata_reg  <= {2'b00, ended_reg, started_reg, duck_reg,
                                         duck_now_reg, target_reg, res_gain_reg};
                        m_tvalid_reg <= 1'b1;
                        sum_reg      <= '0;
                        peak_reg     <= '0;
                        cnt_reg      <= '0;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // shared log2 unit
    sad_log2 u_log2 (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (log_start),
        .value  (log_value),
        .done   (log_done),
        .result (log_res)
    );

    // envelope step divider
    sad_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .divisor  ({1'b0, ms_sel, 5'b0} + {2'b0, ms_sel, 4'b0}),
        .done     (div_done),
        .quotient (div_q)
    );

endmodule

// File: rtl/core/sad_log2.sv
// iterative log2 unit in Q16: normalize one bit a cycle, then 16 squaring rounds
// depends on sad_pkg
module sad_log2 (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [sad_pkg::ACC_W-1:0]     value,
    output logic                          done,
    output logic [sad_pkg::LOG_W-1:0]     result
);

    typedef enum logic [1:0] {L_IDLE, L_NORM, L_MUL, L_SQ} lstate_t;

    lstate_t     state_reg;
    logic [41:0] m_reg;
    logic [5:0]  p_reg;
    logic [30:0] mant_reg;
    logic [61:0] prod_reg;
    logic [15:0] frac_reg;
    logic [3:0]  i_reg;
    logic        done_reg;
    logic [31:0] sq;

    assign sq     = prod_reg[61:30];
    assign done   = done_reg;
    assign result = {p_reg, frac_reg};

    // sequencer and datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            done_reg  <= 1'b0;
            m_reg     <= '0;
            p_reg     <= '0;
            mant_reg  <= '0;
            prod_reg  <= '0;
            frac_reg  <= '0;
            i_reg     <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                L_IDLE:
                begin
                    if (start)
                    begin
                        m_reg     <= value;
                        p_reg     <= 6'd41;
                        frac_reg  <= '0;
                        state_reg <= L_NORM;
                    end
                end
                L_NORM:
                begin
                    if (m_reg[41])
                    begin
                        mant_reg  <= m_reg[41:11];
                        i_reg     <= '0;
                        state_reg <= L_MUL;
                    end
                    else
                    begin
                        m_reg <= {m_reg[40:0], 1'b0};
                        p_reg <= p_reg - 6'd1;
                    end
                end
                L_MUL:
                begin
                    prod_reg  <= 62'(mant_reg) * 62'(mant_reg);
                    state_reg <= L_SQ;
                end
                L_SQ:
                begin
                    frac_reg[4'd15 - i_reg] <= sq[31];
                    mant_reg <= sq[31] ? sq[31:1] : sq[30:0];
                    i_reg    <= i_reg + 4'd1;
                    if (i_reg == 4'd15)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= L_IDLE;
                    end
                    else
                    begin
                        state_reg <= L_MUL;
                    end
                end
                default: state_reg <= L_IDLE;
            endcase
        end
    end

endmodule

// File: rtl/core/sad_div.sv
// restoring divider for the envelope step: 65536 / divisor, one bit a cycle
// depends on sad_pkg
module sad_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [sad_pkg::DIVS_W-1:0]    divisor,
    output logic                          done,
    output logic [sad_pkg::GAIN_W-1:0]    quotient
);

    localparam logic [16:0] DIVIDEND = 17'h10000;

    typedef enum logic {D_IDLE, D_RUN} dstate_t;

    dstate_t     state_reg;
    logic [22:0] rem_reg;
    logic [21:0] div_reg;
    logic [16:0] q_reg;
    logic [4:0]  i_reg;
    logic        done_reg;
    logic [22:0] rem_t;
    logic        fits;

    assign rem_t    = {rem_reg[21:0], DIVIDEND[i_reg]};
    assign fits     = rem_t >= {1'b0, div_reg};
    assign done     = done_reg;
    assign quotient = q_reg;

    // one quotient bit per cycle, msb first
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
            rem_reg   <= '0;
            div_reg   <= '0;
            q_reg     <= '0;
            i_reg     <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                D_IDLE:
                begin
                    if (start)
                    begin
                        rem_reg   <= '0;
                        div_reg   <= divisor;
                        q_reg     <= '0;
                        i_reg     <= 5'd16;
                        state_reg <= D_RUN;
                    end
                end
                D_RUN:
                begin
                    rem_reg <= fits ? (rem_t - {1'b0, div_reg}) : rem_t;
                    q_reg   <= {q_reg[15:0], fits};
                    i_reg   <= i_reg - 5'd1;
                    if (i_reg == 5'd0)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= D_IDLE;
                    end
                end
                default: state_reg <= D_IDLE;
            endcase
        end
    end

endmodule
